### hw/rtl/hamming_sec_codec_defines.svh
// assertion macros for the hamming codec
`ifndef HAMMING_SEC_CODEC_DEFINES_SVH
`define HAMMING_SEC_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
`define HSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hamming codec check failed");
`define HSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hamming codec forbidden condition");
`else
`define HSC_ASSERT(lbl, clk, rst_n, prop)
`define HSC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hw/rtl/hsc_pkg.sv
package hsc_pkg;

	localparam int LEN_W = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN     = 1'd1;

	localparam logic [LEN_W-1:0] MSG_LEN_RESET = 7'd4;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic start_scan;
		logic start_emit;
		logic issue;
		logic accum;
		logic send;
	} cmd_t;

	typedef struct packed {
		logic last_in;
		logic issue_done;
		logic fetched;
		logic fetch_last;
		logic out_free;
	} sts_t;

	// code word length for k data bits: add parity positions while they fit
	function automatic logic [7:0] code_len(input logic [7:0] k);
		logic [7:0] n;
		n = k;
		for (int i = 0; i < 7; i++) begin
			if ((8'd1 << i) <= n)
				n = n + 8'd1;
		end
		return n;
	endfunction

	function automatic int max_data_bits(input int max_bits);
		int k;
		k = 1;
		for (int i = 0; i < 64; i++) begin
			if (int'(code_len(8'(k + 1))) <= max_bits)
				k = k + 1;
		end
		return k;
	endfunction

endpackage

### hw/rtl/hsc_ctrl.sv
module hsc_ctrl
	import hsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.last_in) begin
						cmd.start_scan = 1'b1;
						state_next = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.accum = sts.fetched;
				if (sts.fetched && sts.fetch_last) begin
					cmd.start_emit = 1'b1;
					state_next = ST_EMIT;
				end else begin
					cmd.issue = !sts.issue_done;
				end
			end
			ST_EMIT: begin
				cmd.send = sts.fetched && sts.out_free;
				// refill the fetch stage as soon as it drains
				cmd.issue = !sts.issue_done && (!sts.fetched || cmd.send);
				if (cmd.send && sts.fetch_last)
					state_next = ST_LOAD;
			end
			default: begin
				state_next = ST_LOAD;
			end
		endcase
	end

endmodule

### hw/rtl/hsc_datapath.sv
`include "hamming_sec_codec_defines.svh"

module hsc_datapath
	import hsc_pkg::*;
#(
	parameter int MAX_CODE_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [LEN_W-1:0]     cfg_wdata,
	input  logic                 data_bit,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 code_bit,
	output logic                 last_bit,
	output logic [LEN_W-1:0]     error_position,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int AW = $clog2(MAX_CODE_BITS);
	localparam int MAX_DATA = max_data_bits(MAX_CODE_BITS);
	localparam logic [LEN_W-1:0] DEC_CAP = LEN_W'(MAX_CODE_BITS);
	localparam logic [LEN_W-1:0] ENC_CAP = LEN_W'(MAX_DATA);

	logic             decode_mode_q;
	logic [LEN_W-1:0] msg_len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             mode_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] dat_q;
	logic [LEN_W-1:0] syn_q;
	logic             mem_q [MAX_CODE_BITS];

	logic             rd_data_s1;
	logic [LEN_W-1:0] pos_s1;
	logic             par_s1;
	logic             vld_s1;

	logic             out_valid_q;
	logic             code_bit_q;
	logic             last_bit_q;
	logic [LEN_W-1:0] epos_q;

	logic [LEN_W-1:0] len_raw;
	logic [LEN_W-1:0] cap;
	logic [LEN_W-1:0] eff_len;
	logic [7:0]       enc_n;
	logic [LEN_W-1:0] n_next;
	logic             pos_pow2;
	logic [LEN_W-1:0] pos_m1;
	logic [AW-1:0]    rd_addr;
	logic             bit_out;

	always_comb begin
		len_raw = (msg_len_q == '0) ? LEN_W'(1) : msg_len_q;
		cap = decode_mode_q ? DEC_CAP : ENC_CAP;
		eff_len = (len_raw > cap) ? cap : len_raw;
		enc_n = code_len({1'b0, eff_len});
		n_next = decode_mode_q ? eff_len : enc_n[LEN_W-1:0];
		pos_m1 = pos_q - LEN_W'(1);
		pos_pow2 = (pos_q & pos_m1) == '0;
		rd_addr = mode_q ? pos_m1[AW-1:0] : dat_q[AW-1:0];
		// parity positions of an encoded word take their bit from the syndrome
		if (mode_q)
			bit_out = rd_data_s1 ^ (pos_s1 == syn_q);
		else if (par_s1)
			bit_out = |(syn_q & pos_s1);
		else
			bit_out = rd_data_s1;
	end

	always_comb begin
		sts.last_in = ({1'b0, cnt_q} + 8'd1) >= {1'b0, eff_len};
		sts.issue_done = pos_q > n_q;
		sts.fetched = vld_s1;
		sts.fetch_last = pos_s1 == n_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			msg_len_q <= MSG_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DECODE_MODE: decode_mode_q <= cfg_wdata[0];
				CFG_MSG_LEN:     msg_len_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			mem_q[cnt_q[AW-1:0]] <= data_bit;
		if (cmd.issue)
			rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= 1'b0;
			n_q <= '0;
			pos_q <= '0;
			dat_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept)
				cnt_q <= sts.last_in ? '0 : cnt_q + LEN_W'(1);
			if (cmd.start_scan) begin
				mode_q <= decode_mode_q;
				n_q <= n_next;
			end
			if (cmd.start_scan || cmd.start_emit) begin
				pos_q <= LEN_W'(1);
				dat_q <= '0;
			end else if (cmd.issue) begin
				pos_q <= pos_q + LEN_W'(1);
				if (!mode_q && !pos_pow2)
					dat_q <= dat_q + LEN_W'(1);
			end
			if (cmd.start_scan || cmd.start_emit)
				vld_s1 <= 1'b0;
			else if (cmd.issue)
				vld_s1 <= 1'b1;
			else if (cmd.accum || cmd.send)
				vld_s1 <= 1'b0;
			if (cmd.send)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pos_s1 <= pos_q;
			par_s1 <= pos_pow2 && !mode_q;
		end
		// syndrome and parity share one sum: xor of the positions of all ones
		if (cmd.start_scan)
			syn_q <= '0;
		else if (cmd.accum && rd_data_s1 && !par_s1)
			syn_q <= syn_q ^ pos_s1;
		if (cmd.send) begin
			code_bit_q <= bit_out;
			last_bit_q <= pos_s1 == n_q;
			epos_q <= mode_q ? syn_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign code_bit = code_bit_q;
	assign last_bit = last_bit_q;
	assign error_position = epos_q;

	`HSC_ASSERT(a_fetch_in_word, clk, arst_n, vld_s1 |-> (pos_s1 != '0 && pos_s1 <= n_q))
	`HSC_ASSERT(a_issue_in_word, clk, arst_n, cmd.issue |-> (pos_q != '0 && pos_q <= n_q))
	`HSC_ASSERT_NEVER(a_use_empty, clk, arst_n, (cmd.send || cmd.accum) && !vld_s1)
	`HSC_ASSERT(a_send_loads, clk, arst_n, cmd.send |=> (out_valid_q && last_bit_q == $past(sts.fetch_last)))

endmodule

### hw/rtl/hamming_sec_codec.sv
// Single-error-correcting Hamming codec fed one bit per transfer. Bits are written into a
// single-port bit store, one per cycle, until msg_len bits (clamped) have arrived. The
// block then makes two passes over the code word of n bits, one store read per cycle
// while the output is not stalled: a scan pass that folds the positions of all ones
// into the syndrome (parity in encode mode) and an emit pass that streams the encoded
// or corrected word out. For a message of L input bits, n is L in decode mode and L
// plus its parity positions in encode mode. No input is taken during the two passes;
// the output register lets the next message load while the last bit waits.
// error_position carries the syndrome on every bit of a decoded word and 0 when encoding.
module hamming_sec_codec
	import hsc_pkg::*;
#(
	parameter int MAX_CODE_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [LEN_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 data_bit,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 code_bit,
	output logic                 last_bit,
	output logic [LEN_W-1:0]     error_position
);

	cmd_t cmd;
	sts_t sts;

	hsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hsc_datapath #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.data_bit       (data_bit),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.code_bit       (code_bit),
		.last_bit       (last_bit),
		.error_position (error_position),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
